### src/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### src/agd_pkg.sv
package agd_pkg;

  localparam int ACT_W     = 8;
  localparam int NIB_W     = 4;
  localparam int NIB_SHIFT = 4;
  localparam logic [NIB_W-1:0] NIB_MASK = 4'hF;
  localparam int LANES     = 2;
  localparam int PROD_W    = 12;
  localparam int DOT_W     = 24;
  localparam int SUM_W     = 18;
  localparam int SCALE_W   = 32;
  localparam int FRAC_BITS = 24;
  localparam int ACC_W     = 64;
  localparam int SCALED_W  = 2 * SCALE_W - FRAC_BITS;
  localparam int HALF_W    = SCALED_W / 2;

  localparam logic [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};
  localparam logic [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};

  typedef struct packed {
    logic start;
    logic row_end;
    logic zero_en;
  } close_req_t;

endpackage

### src/agd_lane.sv
module agd_lane (
  input  logic signed [agd_pkg::ACT_W-1:0]  act,
  input  logic        [agd_pkg::NIB_W-1:0]  nib,
  output logic signed [agd_pkg::PROD_W-1:0] prod
);
  import agd_pkg::*;

  logic signed [PROD_W-1:0] act_x;
  logic signed [PROD_W-1:0] nib_x;

  always_comb begin
    act_x = PROD_W'(act);
    nib_x = $signed({{(PROD_W-NIB_W){1'b0}}, nib});
    prod  = act_x * nib_x;
  end

endmodule

### src/agd_group.sv
module agd_group (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              accept,
  input  logic                              close,
  input  logic signed [agd_pkg::PROD_W-1:0] prod [agd_pkg::LANES],
  input  logic signed [agd_pkg::ACT_W-1:0]  act  [agd_pkg::LANES],
  output logic signed [agd_pkg::DOT_W-1:0]  dot_next,
  output logic signed [agd_pkg::SUM_W-1:0]  sum_next
);
  import agd_pkg::*;

  logic signed [DOT_W-1:0] group_dot;
  logic signed [SUM_W-1:0] group_act_sum;

  // merge lane results into the running group sums
  always_comb begin
    dot_next = group_dot;
    sum_next = group_act_sum;
    for (int l = 0; l < LANES; l++) begin
      dot_next = dot_next + DOT_W'(prod[l]);
      sum_next = sum_next + SUM_W'(act[l]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      group_dot     <= '0;
      group_act_sum <= '0;
    end else if (accept) begin
      group_dot     <= close ? '0 : dot_next;
      group_act_sum <= close ? '0 : sum_next;
    end
  end

endmodule

### src/agd_close.sv
module agd_close (
  input  logic                               clk,
  input  logic                               rst,
  input  agd_pkg::close_req_t                req,
  input  logic signed [agd_pkg::DOT_W-1:0]   dot_in,
  input  logic signed [agd_pkg::SUM_W-1:0]   sum_in,
  input  logic        [agd_pkg::SCALE_W-1:0] act_scale,
  input  logic        [agd_pkg::SCALE_W-1:0] weight_scale,
  input  logic signed [agd_pkg::SCALE_W-1:0] weight_zero,
  input  logic                               out_ready,
  output logic                               busy,
  output logic                               out_valid,
  output logic        [agd_pkg::ACC_W-1:0]   out_data,
  output logic                               out_sat
);
  import agd_pkg::*;

  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_MUL1 = 7'b0000010,
    ST_MUL2 = 7'b0000100,
    ST_MAG  = 7'b0001000,
    ST_ACC1 = 7'b0010000,
    ST_ACC2 = 7'b0100000,
    ST_EMIT = 7'b1000000
  } close_state_t;

  close_state_t state;
  close_state_t state_next;

  logic                      row_end_q;
  logic                      zen_q;
  logic [DOT_W-1:0]          d_mag;
  logic                      d_neg;
  logic [SUM_W-1:0]          s_mag;
  logic                      s_neg;
  logic [SCALE_W-1:0]        z_mag;
  logic                      z_neg;
  logic [SCALE_W-1:0]        as_q;
  logic [SCALE_W-1:0]        bs_q;
  logic [2*SCALE_W-1:0]      p_w;
  logic [2*SCALE_W-1:0]      p_z;
  logic [SCALED_W-1:0]       w;
  logic [SCALED_W-1:0]       z;
  logic [DOT_W+HALF_W-1:0]   pp_d_lo;
  logic [DOT_W+HALF_W-1:0]   pp_d_hi;
  logic [SUM_W+HALF_W-1:0]   pp_s_lo;
  logic [SUM_W+HALF_W-1:0]   pp_s_hi;
  logic [ACC_W-1:0]          t1_mag;
  logic [ACC_W-1:0]          t2_mag;
  logic [ACC_W-1:0]          row_acc;
  logic                      clip_flag;
  logic [ACC_W:0]            acc1;
  logic [ACC_W:0]            acc2;
  logic                      emit_fire;

  // saturating a + (neg ? -m : m), msb of the result is the clip flag
  function automatic logic [ACC_W:0] sat_addsub(input logic [ACC_W-1:0] a,
                                                input logic [ACC_W-1:0] m,
                                                input logic             neg);
    logic [ACC_W-1:0] s;
    logic             b_sign;
    logic             ovf;
    s      = a + (neg ? ~m : m) + ACC_W'(neg);
    b_sign = neg ? (m != '0) : m[ACC_W-1];
    ovf    = (a[ACC_W-1] == b_sign) && (s[ACC_W-1] != a[ACC_W-1]);
    if (ovf) begin
      return {1'b1, a[ACC_W-1] ? ACC_MIN : ACC_MAX};
    end
    return {1'b0, s};
  endfunction

  assign w         = p_w[2*SCALE_W-1:FRAC_BITS];
  assign z         = p_z[2*SCALE_W-1:FRAC_BITS];
  assign acc1      = sat_addsub(row_acc, t1_mag, d_neg);
  assign acc2      = sat_addsub(row_acc, t2_mag, s_neg ^ z_neg);
  assign busy      = (state != ST_IDLE);
  assign emit_fire = (state == ST_EMIT) && (!out_valid || out_ready);

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (req.start) state_next = ST_MUL1;
      end
      ST_MUL1: state_next = ST_MUL2;
      ST_MUL2: state_next = ST_MAG;
      ST_MAG:  state_next = ST_ACC1;
      ST_ACC1: state_next = ST_ACC2;
      ST_ACC2: state_next = row_end_q ? ST_EMIT : ST_IDLE;
      ST_EMIT: begin
        if (!out_valid || out_ready) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
      row_acc   <= '0;
      clip_flag <= 1'b0;
    end else begin
      state <= state_next;
      if (emit_fire) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_ACC1: begin
          row_acc   <= acc1[ACC_W-1:0];
          clip_flag <= clip_flag | acc1[ACC_W];
        end
        ST_ACC2: begin
          if (zen_q) begin
            row_acc   <= acc2[ACC_W-1:0];
            clip_flag <= clip_flag | acc2[ACC_W];
          end
        end
        ST_EMIT: begin
          if (emit_fire) begin
            row_acc   <= '0;
            clip_flag <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && req.start) begin
      row_end_q <= req.row_end;
      zen_q     <= req.zero_en;
      d_neg     <= dot_in[DOT_W-1];
      d_mag     <= dot_in[DOT_W-1] ? DOT_W'(-dot_in) : DOT_W'(dot_in);
      s_neg     <= sum_in[SUM_W-1];
      s_mag     <= sum_in[SUM_W-1] ? SUM_W'(-sum_in) : SUM_W'(sum_in);
      z_neg     <= weight_zero[SCALE_W-1];
      z_mag     <= weight_zero[SCALE_W-1] ? SCALE_W'(-weight_zero) : SCALE_W'(weight_zero);
      as_q      <= act_scale;
      bs_q      <= weight_scale;
    end
    if (state == ST_MUL1) begin
      p_w <= as_q * bs_q;
      p_z <= as_q * z_mag;
    end
    if (state == ST_MUL2) begin
      pp_d_lo <= d_mag * w[HALF_W-1:0];
      pp_d_hi <= d_mag * w[SCALED_W-1:HALF_W];
      pp_s_lo <= s_mag * z[HALF_W-1:0];
      pp_s_hi <= s_mag * z[SCALED_W-1:HALF_W];
    end
    if (state == ST_MAG) begin
      t1_mag <= ACC_W'(pp_d_lo) + (ACC_W'(pp_d_hi) << HALF_W);
      t2_mag <= ACC_W'(pp_s_lo) + (ACC_W'(pp_s_hi) << HALF_W);
    end
    if (emit_fire) begin
      out_data <= row_acc;
      out_sat  <= clip_flag;
    end
  end

endmodule

### src/int8_int4_affine_group_dot.sv
// a row-end beat's result goes out on m_axis after close states MUL1 to EMIT
// throughput: 1 beat per cycle inside a group; a group-end beat holds the input
//   in MUL1 to ACC2, a row-end beat in EMIT too (longer while the output stalls)
// the group-end close runs two 32x32 multiplies, split 24x40 and 18x40
//   multiplies, two saturating 64-bit adds (2nd if zero_enable), one per cycle
// reset: synchronous active-high rst clears group sums, row accumulator, clip flag and out valid
module int8_int4_affine_group_dot (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // act_even, act_odd, weight_pair, act_scale, weight_scale, weight_zero
  input  logic [119:0] s_axis_tdata,
  // zero_enable, group_end
  input  logic [1:0]   s_axis_tuser,
  input  logic         s_axis_tlast,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // dot_result
  output logic [agd_pkg::ACC_W-1:0] m_axis_tdata,
  // saturated
  output logic [0:0]   m_axis_tuser
);
  import agd_pkg::*;
  `include "assert_macros.svh"

  localparam int AE_LSB = 0;
  localparam int AO_LSB = AE_LSB + ACT_W;
  localparam int WP_LSB = AO_LSB + ACT_W;
  localparam int AS_LSB = WP_LSB + 2 * NIB_W;
  localparam int BS_LSB = AS_LSB + SCALE_W;
  localparam int BZ_LSB = BS_LSB + SCALE_W;
  localparam int USER_ZEN  = 0;
  localparam int USER_GEND = 1;

  logic                      accept;
  logic                      busy;
  logic                      out_sat;
  logic [2*NIB_W-1:0]        weight_pair;
  logic signed [ACT_W-1:0]   act  [LANES];
  logic signed [PROD_W-1:0]  prod [LANES];
  logic signed [DOT_W-1:0]   dot_next;
  logic signed [SUM_W-1:0]   sum_next;
  close_req_t                req;

  assign s_axis_tready = !busy;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign weight_pair   = s_axis_tdata[WP_LSB +: 2*NIB_W];
  assign act[0]        = s_axis_tdata[AE_LSB +: ACT_W];
  assign act[1]        = s_axis_tdata[AO_LSB +: ACT_W];

  assign req.start   = accept && (s_axis_tuser[USER_GEND] || s_axis_tlast);
  assign req.row_end = s_axis_tlast;
  assign req.zero_en = s_axis_tuser[USER_ZEN];

  for (genvar l = 0; l < LANES; l++) begin : g_lane
    logic [NIB_W-1:0] nib;
    assign nib = NIB_W'(weight_pair >> (l * NIB_SHIFT)) & NIB_MASK;
    agd_lane u_lane (
      .act  (act[l]),
      .nib  (nib),
      .prod (prod[l])
    );
  end

  agd_group u_group (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .close    (req.start),
    .prod     (prod),
    .act      (act),
    .dot_next (dot_next),
    .sum_next (sum_next)
  );

  agd_close u_close (
    .clk          (clk),
    .rst          (rst),
    .req          (req),
    .dot_in       (dot_next),
    .sum_in       (sum_next),
    .act_scale    (s_axis_tdata[AS_LSB +: SCALE_W]),
    .weight_scale (s_axis_tdata[BS_LSB +: SCALE_W]),
    .weight_zero  (s_axis_tdata[BZ_LSB +: SCALE_W]),
    .out_ready    (m_axis_tready),
    .busy         (busy),
    .out_valid    (m_axis_tvalid),
    .out_data     (m_axis_tdata),
    .out_sat      (out_sat)
  );

  assign m_axis_tuser[0] = out_sat;

  `ASSERT_NEXT(a_plain_beat_keeps_ready, clk, rst, accept && !s_axis_tuser[USER_GEND] && !s_axis_tlast, s_axis_tready, "plain beat stalled the input")
  `ASSERT_NEXT(a_close_blocks_input, clk, rst, req.start, !s_axis_tready, "input open during group close")
  `ASSERT_IMPLY(a_result_after_close, clk, rst, $rose(m_axis_tvalid), !$past(s_axis_tready), "result without a row close")

endmodule
